>>> sv/mshw_pkg.sv
package mshw_pkg;

   localparam int NUM_SLOTS = 16;
   localparam int SLOT_W = 4;
   localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int CNT_W = $clog2(NUM_SLOTS + 1);
   localparam int TIME_W = 64;
   localparam int TMO_W = 36;
   localparam int NUM_TYPES = 6;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [TMO_W-1:0] ONE_SEC_US = TMO_W'(1000000);
   localparam logic [TMO_W-1:0] DEFAULT_TMO_US = TMO_W'(60000000);

   localparam logic [1:0] RS_NOT_STARTED = 2'd0;
   localparam logic [1:0] RS_RUNNING = 2'd1;
   localparam logic [1:0] RS_STOPPED = 2'd3;

   typedef enum logic [2:0] {
      MODE_REGISTER   = 3'd0,
      MODE_UNREGISTER = 3'd1,
      MODE_HEARTBEAT  = 3'd2,
      MODE_SET_RUN    = 3'd3,
      MODE_SWEEP      = 3'd4,
      MODE_CLEAR      = 3'd5
   } mode_type;

   typedef enum logic [2:0] {
      CELL_NOP,
      CELL_ALLOC,
      CELL_RELEASE,
      CELL_BEAT,
      CELL_SET_RUN,
      CELL_CLEAR
   } cell_op_type;

   typedef struct packed {
      logic [2:0] mode;
      logic [TIME_W-1:0] now_us;
      logic [SLOT_W-1:0] slot;
      logic [2:0] client_type;
      logic [1:0] run_state;
   } req_item_type;

   typedef struct packed {
      logic result_valid;
      logic op_ok;
      logic [SLOT_W-1:0] slot_out;
      logic health;
      logic new_timeout;
      logic [TIME_W-1:0] elapsed_us;
      logic last;
   } rsp_item_type;

   typedef struct packed {
      cell_op_type op;
      logic [TIME_W-1:0] now_us;
      logic [2:0] client_type;
      logic [1:0] run_state;
   } cell_cmd_type;

   typedef struct packed {
      logic tok;
      logic [TIME_W-1:0] now_us;
   } sweep_bus_type;

   typedef struct packed {
      logic registered;
      logic health;
   } cell_stat_type;

   typedef struct packed {
      logic health;
      logic new_timeout;
      logic [TIME_W-1:0] elapsed_us;
   } cell_res_type;

   typedef logic [NUM_TYPES-1:0][TMO_W-1:0] tmo_table_type;

endpackage

>>> sv/mshw_cell.sv
module mshw_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  mshw_pkg::cell_cmd_type  cmd,
   input  logic                  sel,
   input  logic                  visit,
   input  mshw_pkg::tmo_table_type tmo_us,
   input  mshw_pkg::sweep_bus_type sweep_in,
   output mshw_pkg::sweep_bus_type sweep_out,
   output mshw_pkg::cell_stat_type stat,
   output mshw_pkg::cell_res_type  res
);

   logic registered_ff, registered_in;
   logic health_ff, health_in;
   logic [1:0] run_state_ff, run_state_in;
   logic [2:0] type_ff, type_in;
   logic [mshw_pkg::TIME_W-1:0] beat_ff, beat_in;
   logic tok_ff;
   logic [mshw_pkg::TIME_W-1:0] now_ff;

   logic running;
   logic timed_out;
   logic [mshw_pkg::TMO_W-1:0] limit;
   logic [mshw_pkg::TIME_W-1:0] elapsed;

   always_comb begin
      if (type_ff < 3'(mshw_pkg::NUM_TYPES)) begin
         limit = tmo_us[type_ff];
      end else begin
         limit = mshw_pkg::DEFAULT_TMO_US;
      end
      running = (run_state_ff == mshw_pkg::RS_RUNNING);
      elapsed = running ? (now_ff - beat_ff) : '0;
      timed_out = running && (elapsed > mshw_pkg::TIME_W'(limit));
   end

   always_comb begin
      registered_in = registered_ff;
      health_in = health_ff;
      run_state_in = run_state_ff;
      type_in = type_ff;
      beat_in = beat_ff;
      if (tok_ff && visit) begin
         health_in = timed_out;
      end
      unique case (cmd.op)
         mshw_pkg::CELL_ALLOC: begin
            if (sel) begin
               registered_in = 1'b1;
               health_in = 1'b0;
               run_state_in = mshw_pkg::RS_NOT_STARTED;
               type_in = cmd.client_type;
               beat_in = cmd.now_us;
            end
         end
         mshw_pkg::CELL_RELEASE: begin
            if (sel) begin
               registered_in = 1'b0;
               run_state_in = mshw_pkg::RS_STOPPED;
            end
         end
         mshw_pkg::CELL_BEAT: begin
            if (sel) begin
               beat_in = cmd.now_us;
            end
         end
         mshw_pkg::CELL_SET_RUN: begin
            if (sel) begin
               run_state_in = cmd.run_state;
            end
         end
         mshw_pkg::CELL_CLEAR: begin
            registered_in = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         registered_ff <= 1'b0;
         health_ff <= 1'b0;
         run_state_ff <= mshw_pkg::RS_NOT_STARTED;
         tok_ff <= 1'b0;
      end else begin
         registered_ff <= registered_in;
         health_ff <= health_in;
         run_state_ff <= run_state_in;
         tok_ff <= sweep_in.tok;
      end
   end

   always_ff @(posedge clock) begin
      type_ff <= type_in;
      beat_ff <= beat_in;
      now_ff <= sweep_in.now_us;
   end

   assign sweep_out.tok = tok_ff;
   assign sweep_out.now_us = now_ff;
   assign stat.registered = registered_ff;
   assign stat.health = health_ff;
   assign res.health = timed_out;
   assign res.new_timeout = timed_out && !health_ff;
   assign res.elapsed_us = elapsed;

endmodule

>>> sv/multi_slot_heartbeat_watchdog.sv
// Single-slot ops: one item per cycle while not busy, result strobed the cycle after start.
// Check sweep: a token walks the slot chain one cell per cycle; each registered slot
// below the allocation count reports as it passes, and busy stays high until the token
// leaves the last cell. An empty sweep answers the cycle after start like any other item.
// Reset clears slot allocation, run states, health and timeouts (60 s); type and
// time stamp storage is written at register. The receiver cannot stall the results.
module multi_slot_heartbeat_watchdog (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   output logic                                    busy,
   input  mshw_pkg::req_item_type                  req,
   output logic                                    rsp_valid,
   output mshw_pkg::rsp_item_type                  rsp,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [mshw_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [mshw_pkg::CSR_DATA_W-1:0]         csr_data
);

   mshw_pkg::tmo_table_type tmo_ff;
   logic [mshw_pkg::CNT_W-1:0] alloc_ff, alloc_in;
   logic busy_ff, busy_in;
   logic rsp_valid_ff, rsp_valid_in;
   mshw_pkg::rsp_item_type rsp_ff, rsp_in;

   mshw_pkg::cell_cmd_type cmd;
   logic [mshw_pkg::NUM_SLOTS-1:0] sel;
   logic [mshw_pkg::NUM_SLOTS-1:0] visit;
   logic [mshw_pkg::NUM_SLOTS-1:0] health_vec;
   mshw_pkg::sweep_bus_type chain [mshw_pkg::NUM_SLOTS+1];
   mshw_pkg::cell_stat_type stat [mshw_pkg::NUM_SLOTS];
   mshw_pkg::cell_res_type res [mshw_pkg::NUM_SLOTS];

   logic accept;
   logic slot_ok;
   logic [mshw_pkg::IDX_W-1:0] slot_idx;

   assign accept = start && !busy_ff;
   assign slot_ok = (int'(req.slot) < mshw_pkg::NUM_SLOTS);
   assign slot_idx = req.slot[mshw_pkg::IDX_W-1:0];
   assign csr_ready = 1'b1;

   // timeouts are kept in microseconds, zero seconds meaning the default
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int t = 0; t < mshw_pkg::NUM_TYPES; t++) begin
            tmo_ff[t] <= mshw_pkg::DEFAULT_TMO_US;
         end
      end else if (csr_valid && csr_ready
                   && (csr_index < mshw_pkg::CSR_IDX_W'(mshw_pkg::NUM_TYPES))) begin
         if (csr_data == '0) begin
            tmo_ff[csr_index] <= mshw_pkg::DEFAULT_TMO_US;
         end else begin
            tmo_ff[csr_index] <= mshw_pkg::TMO_W'(csr_data) * mshw_pkg::ONE_SEC_US;
         end
      end
   end

   always_comb begin
      for (int i = 0; i < mshw_pkg::NUM_SLOTS; i++) begin
         visit[i] = stat[i].registered && (i < int'(alloc_ff));
         health_vec[i] = stat[i].health;
      end
   end

   always_comb begin
      cmd.op = mshw_pkg::CELL_NOP;
      cmd.now_us = req.now_us;
      cmd.client_type = req.client_type;
      cmd.run_state = req.run_state;
      sel = '0;
      alloc_in = alloc_ff;
      busy_in = busy_ff;
      rsp_valid_in = 1'b0;
      rsp_in = '0;
      rsp_in.last = 1'b1;
      chain[0].tok = 1'b0;
      chain[0].now_us = req.now_us;

      if (accept) begin
         rsp_valid_in = 1'b1;
         unique case (mshw_pkg::mode_type'(req.mode))
            mshw_pkg::MODE_REGISTER: begin
               if (int'(alloc_ff) < mshw_pkg::NUM_SLOTS) begin
                  cmd.op = mshw_pkg::CELL_ALLOC;
                  for (int i = 0; i < mshw_pkg::NUM_SLOTS; i++) begin
                     sel[i] = (i == int'(alloc_ff));
                  end
                  alloc_in = alloc_ff + mshw_pkg::CNT_W'(1);
                  rsp_in.result_valid = 1'b1;
                  rsp_in.op_ok = 1'b1;
                  rsp_in.slot_out = mshw_pkg::SLOT_W'(alloc_ff);
               end
            end
            mshw_pkg::MODE_UNREGISTER, mshw_pkg::MODE_HEARTBEAT,
            mshw_pkg::MODE_SET_RUN: begin
               if (slot_ok) begin
                  if (req.mode == mshw_pkg::MODE_UNREGISTER) begin
                     cmd.op = mshw_pkg::CELL_RELEASE;
                  end else if (req.mode == mshw_pkg::MODE_HEARTBEAT) begin
                     cmd.op = mshw_pkg::CELL_BEAT;
                  end else begin
                     cmd.op = mshw_pkg::CELL_SET_RUN;
                  end
                  for (int i = 0; i < mshw_pkg::NUM_SLOTS; i++) begin
                     sel[i] = (i == int'(req.slot));
                  end
                  rsp_in.result_valid = 1'b1;
                  rsp_in.op_ok = 1'b1;
                  rsp_in.slot_out = req.slot;
                  rsp_in.health = health_vec[slot_idx];
               end
            end
            mshw_pkg::MODE_SWEEP: begin
               rsp_in.op_ok = 1'b1;
               if (visit != '0) begin
                  // launch the token; the cells report as it passes
                  rsp_valid_in = 1'b0;
                  chain[0].tok = 1'b1;
                  busy_in = 1'b1;
               end
            end
            mshw_pkg::MODE_CLEAR: begin
               cmd.op = mshw_pkg::CELL_CLEAR;
               alloc_in = '0;
               rsp_in.op_ok = 1'b1;
            end
            default: begin
            end
         endcase
      end else if (busy_ff) begin
         for (int i = 0; i < mshw_pkg::NUM_SLOTS; i++) begin
            if (chain[i+1].tok && visit[i]) begin
               rsp_valid_in = 1'b1;
               rsp_in.result_valid = 1'b1;
               rsp_in.op_ok = 1'b1;
               rsp_in.slot_out = mshw_pkg::SLOT_W'(i);
               rsp_in.health = res[i].health;
               rsp_in.new_timeout = res[i].new_timeout;
               rsp_in.elapsed_us = res[i].elapsed_us;
               rsp_in.last = (((visit >> i) >> 1) == '0);
            end
         end
         if (chain[mshw_pkg::NUM_SLOTS].tok) begin
            busy_in = 1'b0;
         end
      end
   end

   for (genvar g = 0; g < mshw_pkg::NUM_SLOTS; g++) begin : g_cell
      mshw_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cmd       (cmd),
         .sel       (sel[g]),
         .visit     (visit[g]),
         .tmo_us    (tmo_ff),
         .sweep_in  (chain[g]),
         .sweep_out (chain[g+1]),
         .stat      (stat[g]),
         .res       (res[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alloc_ff <= '0;
         busy_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         alloc_ff <= alloc_in;
         busy_ff <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign busy = busy_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp = rsp_ff;

endmodule
